[rtl/skot_pkg.sv]
// ----------------------------------------------------------------------------
// skot_pkg: shared types and constants of the session key owner table
// Table size, entry layout, operation and outcome codes, controller states.
// ----------------------------------------------------------------------------
package skot_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int KEY_BYTES   = 31;
  localparam int KEY_BITS    = KEY_BYTES * 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = IDX_W + 1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [55:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } key_t;

  typedef struct packed {
    logic       valid;
    key_t       key;
    logic [7:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    OP_LOOKUP     = 2'd0,
    OP_REGISTER   = 2'd1,
    OP_UNREGISTER = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    OUT_HIT         = 3'd0,
    OUT_MISS        = 3'd1,
    OUT_UPDATED     = 3'd2,
    OUT_INSERTED    = 3'd3,
    OUT_FULL        = 3'd4,
    OUT_REMOVED     = 3'd5,
    OUT_REMOVE_MISS = 3'd6
  } outcome_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

[rtl/skot_ram.sv]
// ----------------------------------------------------------------------------
// skot_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module skot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/skot_key_norm.sv]
// ----------------------------------------------------------------------------
// skot_key_norm: key normalizer
// Zeroes every byte after the first zero byte of the 31-byte key.
// ----------------------------------------------------------------------------
module skot_key_norm (
  input  skot_pkg::key_t key_raw,
  output skot_pkg::key_t key_norm
);

  logic [skot_pkg::KEY_BITS-1:0] flat_in;
  logic [skot_pkg::KEY_BITS-1:0] flat_out;
  logic                          ended;

  assign flat_in = key_raw;

  always_comb begin
    ended    = 1'b0;
    flat_out = flat_in;
    for (int b = 0; b < skot_pkg::KEY_BYTES; b++) begin
      if (ended) begin
        flat_out[b*8 +: 8] = 8'h00;
      end else if (flat_in[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
  end

  assign key_norm = skot_pkg::key_t'(flat_out);

endmodule

[rtl/session_key_owner_table.sv]
// ----------------------------------------------------------------------------
// session_key_owner_table: session key to owner worker table
// Scans a RAM of entries for the first valid matching key and the first
// free slot, then answers lookup, register/update or unregister.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  in      | input     | in_valid / in_ready | operation, key_word0..3,
//          |           |                     | key_overlong, owner_worker
//  out     | output    | out_valid/out_ready | outcome, found_worker
//
// Scan: each word scans the entry RAM one entry per cycle through its
//   single read port; a matching entry ends the scan early.
// Reset: after rst the controller sweeps the RAM clearing every valid bit,
//   with in_ready low.
// Stalls: a finished result sits in the output register; the next word is
//   taken meanwhile, and its result waits in the finish state until the
//   output register is free. Table writes happen in that finish cycle.
//
module session_key_owner_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [63:0] key_word0,
  input  logic [63:0] key_word1,
  input  logic [63:0] key_word2,
  input  logic [55:0] key_word3,
  input  logic        key_overlong,
  input  logic [7:0]  owner_worker,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  outcome,
  output logic [7:0]  found_worker
);

  localparam skot_pkg::idx_t LAST_IDX   = skot_pkg::idx_t'(skot_pkg::TABLE_DEPTH - 1);
  localparam skot_pkg::cnt_t DEPTH_CNT  = skot_pkg::cnt_t'(skot_pkg::TABLE_DEPTH);

  skot_pkg::state_t state;
  skot_pkg::state_t state_next;

  // captured word
  skot_pkg::op_t    op;
  skot_pkg::key_t   key;
  logic             overlong;
  logic [7:0]       owner;

  // scan tracking
  skot_pkg::cnt_t   iss;          // issue address; also clear sweep address
  logic             chk;          // read data is valid this cycle
  skot_pkg::idx_t   chk_idx;      // entry index of the read data
  logic             match_found;
  skot_pkg::idx_t   match_idx;
  logic [7:0]       match_owner;
  logic             free_found;
  skot_pkg::idx_t   free_idx;

  // RAM port
  logic             ram_we;
  skot_pkg::idx_t   ram_waddr;
  skot_pkg::entry_t ram_wdata;
  logic             ram_re;
  skot_pkg::entry_t ram_rdata;
  logic [skot_pkg::ENTRY_W-1:0] ram_rdata_raw;

  skot_pkg::key_t   key_in;
  skot_pkg::key_t   key_in_norm;

  logic             in_fire;
  logic             out_free;
  logic             hit;
  logic             is_free;
  logic             finish;
  skot_pkg::outcome_t res_outcome;
  logic [7:0]       res_worker;

  assign key_in = '{w3: key_word3, w2: key_word2, w1: key_word1, w0: key_word0};

  skot_key_norm u_norm (
    .key_raw  (key_in),
    .key_norm (key_in_norm)
  );

  skot_ram #(
    .WIDTH (skot_pkg::ENTRY_W),
    .DEPTH (skot_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss[skot_pkg::IDX_W-1:0]),
    .rdata (ram_rdata_raw)
  );

  assign ram_rdata = skot_pkg::entry_t'(ram_rdata_raw);

  // overlong keys never match
  assign hit      = chk && ram_rdata.valid && !overlong && (ram_rdata.key == key);
  assign is_free  = chk && !ram_rdata.valid;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skot_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, RAM control and result
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = iss[skot_pkg::IDX_W-1:0];
    ram_wdata   = '{valid: 1'b0, key: key, owner: owner};
    finish      = 1'b0;
    res_outcome = skot_pkg::OUT_MISS;
    res_worker  = 8'h00;

    // outcome and returned worker of the finishing word
    unique case (op)
      skot_pkg::OP_LOOKUP: begin
        if (match_found) begin
          res_outcome = skot_pkg::OUT_HIT;
          res_worker  = match_owner;
        end
      end
      skot_pkg::OP_REGISTER: begin
        if (match_found) begin
          res_outcome = skot_pkg::OUT_UPDATED;
        end else if (free_found) begin
          res_outcome = skot_pkg::OUT_INSERTED;
        end else begin
          res_outcome = skot_pkg::OUT_FULL;
        end
      end
      skot_pkg::OP_UNREGISTER: begin
        res_outcome = match_found ? skot_pkg::OUT_REMOVED : skot_pkg::OUT_REMOVE_MISS;
      end
      default: begin
        res_outcome = skot_pkg::OUT_MISS;
      end
    endcase

    unique case (state)
      skot_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (iss[skot_pkg::IDX_W-1:0] == LAST_IDX) begin
          state_next = skot_pkg::ST_IDLE;
        end
      end
      skot_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = skot_pkg::ST_SCAN;
        end
      end
      skot_pkg::ST_SCAN: begin
        ram_re = (iss < DEPTH_CNT);
        if (hit || (chk && (chk_idx == LAST_IDX))) begin
          state_next = skot_pkg::ST_FINISH;
        end
      end
      skot_pkg::ST_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = skot_pkg::ST_IDLE;
          if (op == skot_pkg::OP_REGISTER) begin
            ram_we    = match_found || free_found;
            ram_waddr = match_found ? match_idx : free_idx;
            ram_wdata = '{valid: 1'b1, key: key, owner: owner};
          end else if (op == skot_pkg::OP_UNREGISTER) begin
            ram_we    = match_found;
            ram_waddr = match_idx;
          end
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iss       <= '0;
      chk       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == skot_pkg::ST_CLEAR) begin
        iss <= iss + skot_pkg::cnt_t'(1);
      end else if (in_fire) begin
        iss <= '0;
        chk <= 1'b0;
      end else if (state == skot_pkg::ST_SCAN) begin
        iss <= iss + skot_pkg::cnt_t'(ram_re);
        chk <= ram_re;
      end

      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op          <= skot_pkg::op_t'(operation);
      key         <= key_in_norm;
      overlong    <= key_overlong;
      owner       <= owner_worker;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else if (state == skot_pkg::ST_SCAN) begin
      chk_idx <= iss[skot_pkg::IDX_W-1:0];
      if (is_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
      if (hit) begin
        match_found <= 1'b1;
        match_idx   <= chk_idx;
        match_owner <= ram_rdata.owner;
      end
    end

    if (finish) begin
      outcome      <= res_outcome;
      found_worker <= res_worker;
    end
  end

endmodule

[sim/session_key_owner_table_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_key_owner_table_test: self-checking bench for the key owner table
// Drives lookup, register and unregister words through the valid/ready
// input, keeps a shadow copy of the table to work out each outcome, and
// compares every returned word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module session_key_owner_table_test;
  import skot_pkg::*;

  // Code 3 is not a defined operation; the block must answer it with a miss.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Longest correct silence: reset sweep, a full scan, receiver hold-off
  // and idle gaps. The watchdog gets many times that.
  localparam int WATCHDOG_CYCLES = 20 * (TABLE_DEPTH + 8);
  localparam int TAIL_CYCLES     = TABLE_DEPTH + 8;
  localparam int POOL_SIZE       = 16;
  localparam int RANDOM_WORDS    = 255;

  typedef struct packed {
    logic [1:0] op;
    key_t       key;
    logic       overlong;
    logic [7:0] owner;
  } item_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [7:0] worker;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [63:0] key_word0;
  logic [63:0] key_word1;
  logic [63:0] key_word2;
  logic [55:0] key_word3;
  logic        key_overlong;
  logic [7:0]  owner_worker;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  outcome;
  logic [7:0]  found_worker;

  // Shadow of the table contents, updated in acceptance order.
  logic       shadow_valid [TABLE_DEPTH];
  key_t       shadow_key   [TABLE_DEPTH];
  logic [7:0] shadow_owner [TABLE_DEPTH];

  reply_t expected_replies[$];
  int     mismatch_count = 0;

  // Traffic shaping, flipped by the test tasks.
  bit source_gaps  = 1'b0;
  bit sink_gaps    = 1'b0;
  int hold_request = 0;

  key_t anchor_key;
  key_t key_pool [POOL_SIZE];
  int   pool_len [POOL_SIZE];

  session_key_owner_table DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .key_word0    (key_word0),
    .key_word1    (key_word1),
    .key_word2    (key_word2),
    .key_word3    (key_word3),
    .key_overlong (key_overlong),
    .owner_worker (owner_worker),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .outcome      (outcome),
    .found_worker (found_worker)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow table
  // --------------------------------------------------------------------------

  // A key ends at its first zero byte; anything after it does not count.
  function automatic key_t trim_key(input key_t k);
    logic [KEY_BITS-1:0] bits;
    bit ended;
    bits  = k;
    ended = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (ended) begin
        bits[b*8 +: 8] = 8'h00;
      end else if (bits[b*8 +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return bits;
  endfunction

  // Applies one word to the shadow table and returns the reply it must get.
  function automatic reply_t apply_table_op(input item_t w);
    key_t   k;
    reply_t r;
    int     hit;
    int     slot;
    k        = trim_key(w.key);
    r.outcome = OUT_MISS;
    r.worker  = 8'h00;
    hit       = -1;
    slot      = 0;
    // An overlong key is never compared against stored entries.
    if (!w.overlong) begin
      while (slot < TABLE_DEPTH && hit < 0) begin
        if (shadow_valid[slot] && shadow_key[slot] == k) hit = slot;
        slot = slot + 1;
      end
    end
    case (w.op)
      OP_LOOKUP: begin
        if (hit >= 0) begin
          r.outcome = OUT_HIT;
          r.worker  = shadow_owner[hit];
        end
      end
      OP_REGISTER: begin
        if (hit >= 0) begin
          shadow_owner[hit] = w.owner;
          r.outcome = OUT_UPDATED;
        end else begin
          // First free slot takes the key, or the table is full.
          r.outcome = OUT_FULL;
          slot = 0;
          while (slot < TABLE_DEPTH && r.outcome == OUT_FULL) begin
            if (!shadow_valid[slot]) begin
              shadow_valid[slot] = 1'b1;
              shadow_key[slot]   = k;
              shadow_owner[slot] = w.owner;
              r.outcome = OUT_INSERTED;
            end
            slot = slot + 1;
          end
        end
      end
      OP_UNREGISTER: begin
        if (hit >= 0) begin
          shadow_valid[hit] = 1'b0;
          r.outcome = OUT_REMOVED;
        end else begin
          r.outcome = OUT_REMOVE_MISS;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Key and word builders
  // --------------------------------------------------------------------------

  // len nonzero random bytes, zero padded.
  function automatic key_t random_key(input int len);
    logic [KEY_BITS-1:0] bits;
    bits = '0;
    for (int b = 0; b < len; b++) bits[b*8 +: 8] = 8'($urandom_range(1, 255));
    return bits;
  endfunction

  function automatic key_t filled_key(input int len, input logic [7:0] fill);
    logic [KEY_BITS-1:0] bits;
    bits = '0;
    for (int b = 0; b < len; b++) bits[b*8 +: 8] = fill;
    return bits;
  endfunction

  // Junk in the bytes past the terminator at byte len.
  function automatic key_t add_junk(input key_t k, input int len);
    logic [KEY_BITS-1:0] bits;
    bits = k;
    for (int b = len + 1; b < KEY_BYTES; b++) bits[b*8 +: 8] = 8'($urandom_range(0, 255));
    return bits;
  endfunction

  function automatic int random_len();
    return ($urandom_range(0, 3) == 0) ? KEY_BYTES : $urandom_range(0, KEY_BYTES - 1);
  endfunction

  function automatic item_t make_word(input logic [1:0] op, input key_t k,
                                      input logic ov, input logic [7:0] owner);
    item_t w;
    w.op       = op;
    w.key      = k;
    w.overlong = ov;
    w.owner    = owner;
    return w;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(50, 300);
  endfunction

  // --------------------------------------------------------------------------
  // Input side: entered and left at a falling edge, in_valid left high.
  // --------------------------------------------------------------------------
  task automatic send_word(input item_t w);
    int gap;
    gap = (source_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation    = w.op;
    key_word0    = w.key.w0;
    key_word1    = w.key.w1;
    key_word2    = w.key.w2;
    key_word3    = w.key.w3;
    key_overlong = w.overlong;
    owner_worker = w.owner;
    in_valid     = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    // Block works in order, so predicting at acceptance keeps the queue aligned.
    expected_replies.push_back(apply_table_op(w));
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern driven at the falling edge.
  // --------------------------------------------------------------------------
  initial begin : sink_driver
    int pause;
    pause     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        pause        = hold_request;
        hold_request = 0;
      end
      if (pause > 0) begin
        out_ready = 1'b0;
        pause     = pause - 1;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        pause     = pick_gap() - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Result checker: each accepted word against the oldest prediction.
  always @(posedge clk) begin
    reply_t exp_reply;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result outcome %0d found_worker %0d",
                 $time, outcome, found_worker);
        mismatch_count = mismatch_count + 1;
      end else begin
        exp_reply = expected_replies.pop_front();
        if (outcome !== exp_reply.outcome) begin
          $display("%0t: outcome expected %0d actual %0d",
                   $time, exp_reply.outcome, outcome);
          mismatch_count = mismatch_count + 1;
        end
        if (found_worker !== exp_reply.worker) begin
          $display("%0t: found_worker expected %0d actual %0d",
                   $time, exp_reply.worker, found_worker);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet = quiet + 1;
    end
    $display("%0t: timeout, no word moved for %0d cycles", $time, WATCHDOG_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Nothing stored yet: every operation misses, including the unused code.
  task automatic test_empty_table();
    key_t k;
    k = random_key(12);
    send_word(make_word(OP_LOOKUP, k, 1'b0, 8'h00));
    send_word(make_word(OP_UNREGISTER, k, 1'b0, 8'h00));
    send_word(make_word(OP_UNUSED, k, 1'b0, 8'h5A));
  endtask

  // Insert, hit, owner update, hit with the new owner; owner extremes.
  task automatic test_register_update();
    anchor_key = random_key(9);
    send_word(make_word(OP_REGISTER, anchor_key, 1'b0, 8'h00));
    send_word(make_word(OP_LOOKUP, anchor_key, 1'b0, 8'h33));
    send_word(make_word(OP_REGISTER, anchor_key, 1'b0, 8'hFF));
    send_word(make_word(OP_LOOKUP, anchor_key, 1'b0, 8'h00));
  endtask

  // Empty key and a full 31-byte all-ones key.
  task automatic test_key_extremes();
    key_t ones;
    ones = filled_key(KEY_BYTES, 8'hFF);
    send_word(make_word(OP_REGISTER, '0, 1'b0, 8'hFF));
    // Junk after a zero first byte still reads as the empty key.
    send_word(make_word(OP_LOOKUP, add_junk('0, 0), 1'b0, 8'h00));
    send_word(make_word(OP_REGISTER, ones, 1'b0, 8'h00));
    send_word(make_word(OP_LOOKUP, ones, 1'b0, 8'hFF));
  endtask

  // Stored with junk past the terminator, found with a clean key.
  task automatic test_trailing_junk();
    key_t k;
    k = random_key(5);
    send_word(make_word(OP_REGISTER, add_junk(k, 5), 1'b0, 8'h42));
    send_word(make_word(OP_LOOKUP, k, 1'b0, 8'h00));
  endtask

  // Overlong keys never match but register still inserts a truncated copy,
  // which leaves two entries with one key; removal takes the lower one first.
  task automatic test_overlong_key();
    key_t k;
    k = random_key(10);
    send_word(make_word(OP_REGISTER, k, 1'b0, 8'h11));
    send_word(make_word(OP_REGISTER, k, 1'b1, 8'h22));
    send_word(make_word(OP_LOOKUP, k, 1'b1, 8'h00));
    send_word(make_word(OP_UNREGISTER, k, 1'b1, 8'h00));
    send_word(make_word(OP_LOOKUP, k, 1'b0, 8'h00));
    send_word(make_word(OP_UNREGISTER, k, 1'b0, 8'h00));
    send_word(make_word(OP_LOOKUP, k, 1'b0, 8'h00));
    send_word(make_word(OP_UNREGISTER, k, 1'b0, 8'h00));
    send_word(make_word(OP_UNREGISTER, k, 1'b0, 8'h00));
  endtask

  // Unused code on a stored key must not touch the entry.
  task automatic test_unused_code();
    send_word(make_word(OP_UNUSED, anchor_key, 1'b0, 8'h77));
    send_word(make_word(OP_LOOKUP, anchor_key, 1'b0, 8'h00));
  endtask

  // Receiver stalls for several scan times while words keep coming, so the
  // output register and the finish stage both fill and in_ready drops.
  task automatic test_output_backpressure();
    source_gaps  = 1'b0;
    sink_gaps    = 1'b0;
    hold_request = 3 * (TABLE_DEPTH + 8);
    repeat (5) begin
      send_word(make_word(OP_REGISTER, random_key(random_len()), 1'b0,
                          8'($urandom_range(0, 255))));
    end
  endtask

  // Mostly well-formed traffic over a small pool of live keys, plus noise:
  // overlong keys, the unused code, fresh keys and junk past the terminator.
  task automatic test_random_traffic();
    item_t w;
    int    r;
    int    slot;
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = random_len();
      key_pool[p] = random_key(pool_len[p]);
    end
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Gaps on both sides, then a gap-free stretch, then gaps again.
      source_gaps = (n < RANDOM_WORDS / 3) || (n >= 2 * RANDOM_WORDS / 3);
      sink_gaps   = source_gaps;
      slot = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 15) == 0) begin
        pool_len[slot] = random_len();
        key_pool[slot] = random_key(pool_len[slot]);
      end
      w = make_word(OP_LOOKUP, key_pool[slot], 1'b0, 8'($urandom_range(0, 255)));
      if (pool_len[slot] < KEY_BYTES && $urandom_range(0, 4) == 0) begin
        w.key = add_junk(w.key, pool_len[slot]);
      end
      r = $urandom_range(0, 99);
      if (r < 35) begin
        w.op = OP_REGISTER;
      end else if (r < 70) begin
        w.op = OP_LOOKUP;
      end else if (r < 88) begin
        w.op = OP_UNREGISTER;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            w.key      = random_key(KEY_BYTES);
            w.overlong = 1'b1;
            w.op       = 2'($urandom_range(0, 2));
          end
          1: w.op = OP_UNUSED;
          2: begin
            w.key = random_key(random_len());
            w.op  = OP_REGISTER;
          end
          default: begin
            w.key = add_junk(random_key(pool_len[slot] < KEY_BYTES ? pool_len[slot] : 0),
                             pool_len[slot] < KEY_BYTES ? pool_len[slot] : 0);
            w.op  = 2'($urandom_range(0, 2));
          end
        endcase
      end
      send_word(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    operation    = OP_LOOKUP;
    key_word0    = '0;
    key_word1    = '0;
    key_word2    = '0;
    key_word3    = '0;
    key_overlong = 1'b0;
    owner_worker = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed checks run with a free-flowing receiver, apart from the backpressure test.
    test_empty_table();
    test_register_update();
    test_key_extremes();
    test_trailing_junk();
    test_overlong_key();
    test_unused_code();
    test_output_backpressure();
    test_random_traffic();

    in_valid = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    // A stray extra word would show up within one more scan time.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_replies.size());
      mismatch_count = mismatch_count + 1;
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/skot_pkg.sv
rtl/skot_ram.sv
rtl/skot_key_norm.sv
rtl/session_key_owner_table.sv
sim/session_key_owner_table_test.sv
